// ===== rtl/cmsc_pkg.sv =====
package cmsc_pkg;

	// fixed field widths
	localparam int KIND_BITS      = 3;
	localparam int REQ_BITS       = 3;
	localparam int SLOTS          = 4;
	localparam int SLOT_BITS      = 2;
	localparam int STATE_BITS     = 3;
	localparam int DIR_BITS       = 2;
	localparam int STATUS_BITS    = 2;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 32;

	// parameter defaults
	localparam int NUM_COVERS_DEF = 4;
	localparam int TIMER_BITS_DEF = 32;

	// request kinds
	localparam logic [KIND_BITS-1:0] KIND_OPEN      = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_CLOSE     = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_STOP      = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_STOP_ALL  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_HEARTBEAT = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_TICK      = 3'd5;
	localparam logic [KIND_BITS-1:0] KIND_INIT      = 3'd6;

	// motion directions
	localparam logic [DIR_BITS-1:0] DIR_STOP  = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_OPEN  = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_CLOSE = 2'd2;

	// cover states
	localparam logic [STATE_BITS-1:0] ST_UNKNOWN = 3'd0;
	localparam logic [STATE_BITS-1:0] ST_OPENING = 3'd1;
	localparam logic [STATE_BITS-1:0] ST_CLOSING = 3'd2;
	localparam logic [STATE_BITS-1:0] ST_OPEN    = 3'd3;
	localparam logic [STATE_BITS-1:0] ST_CLOSED  = 3'd4;
	localparam logic [STATE_BITS-1:0] ST_STOPPED = 3'd5;
	localparam logic [STATE_BITS-1:0] ST_ERROR   = 3'd6;

	// status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_HB_BAD  = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_AT_STOP = 2'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_COVER_ENABLE  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LOW    = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HB_TIMEOUT    = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_POLL_INTERVAL = 4'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MOVE0     = 4'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MOVE1     = 4'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MOVE2     = 4'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MOVE3     = 4'd7;

	// per-request control from the supervisor to the cover slices
	typedef struct packed {
		logic                 fire;
		logic [KIND_BITS-1:0] kind;
		logic [REQ_BITS-1:0]  req;
		logic                 hb_ok;
		logic                 failsafe_stop;
		logic                 poll_check;
	} cmsc_ctl_t;

endpackage

// ===== rtl/cmsc_if.sv =====
interface cmsc_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [cmsc_pkg::KIND_BITS-1:0]     kind;
	logic [cmsc_pkg::REQ_BITS-1:0]      cover_req;
	logic [cmsc_pkg::SLOTS-1:0]         open_stop_levels;
	logic [cmsc_pkg::SLOTS-1:0]         close_stop_levels;

	modport source (output valid, kind, cover_req, open_stop_levels, close_stop_levels,
		input ready);
	modport sink (input valid, kind, cover_req, open_stop_levels, close_stop_levels,
		output ready);
endinterface

interface cmsc_res_if;
	logic                                       valid;
	logic                                       ready;
	logic [cmsc_pkg::SLOTS-1:0]                 drive_open;
	logic [cmsc_pkg::SLOTS-1:0]                 drive_close;
	logic [cmsc_pkg::STATUS_BITS-1:0]           status;
	logic [cmsc_pkg::SLOTS*cmsc_pkg::STATE_BITS-1:0] cover_states;
	logic [cmsc_pkg::SLOTS-1:0]                 endstop_events;
	logic [cmsc_pkg::SLOTS-1:0]                 timeout_events;
	logic                                       failsafe_trip;
	logic                                       all_stopped;

	modport source (output valid, drive_open, drive_close, status, cover_states,
		endstop_events, timeout_events, failsafe_trip, all_stopped, input ready);
	modport sink (input valid, drive_open, drive_close, status, cover_states,
		endstop_events, timeout_events, failsafe_trip, all_stopped, output ready);
endinterface

interface cmsc_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [cmsc_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [cmsc_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cmsc_cover.sv =====
module cmsc_cover #(
	parameter int IDX        = 0,
	parameter int TIMER_BITS = cmsc_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmsc_pkg::cmsc_ctl_t                 ctl,
	input  logic                                enable,
	input  logic                                active_low,
	input  logic [cmsc_pkg::CFG_DATA_BITS-1:0]  max_move,
	input  logic                                open_level,
	input  logic                                close_level,
	output logic [cmsc_pkg::DIR_BITS-1:0]       dir_next,
	output logic [cmsc_pkg::STATE_BITS-1:0]     state_next,
	output logic                                endstop_event,
	output logic                                timeout_event,
	output logic                                moving_now
);

	logic [cmsc_pkg::DIR_BITS-1:0]   dir_q;
	logic [cmsc_pkg::STATE_BITS-1:0] state_q;
	logic [TIMER_BITS-1:0]           elapsed_q;
	logic [TIMER_BITS-1:0]           elapsed_next;
	logic [TIMER_BITS-1:0]           elapsed_inc;
	logic                            target;
	logic                            open_hit;
	logic                            close_hit;
	logic                            moving_q;

	assign target    = (ctl.req == cmsc_pkg::REQ_BITS'(IDX)) && enable;
	assign open_hit  = open_level ^ active_low;
	assign close_hit = close_level ^ active_low;
	assign moving_q  = dir_q != cmsc_pkg::DIR_STOP;
	assign moving_now = enable && moving_q;

	always_comb begin
		elapsed_inc = &elapsed_q ? elapsed_q : elapsed_q + 1'b1;
		dir_next      = dir_q;
		state_next    = state_q;
		elapsed_next  = elapsed_q;
		endstop_event = 1'b0;
		timeout_event = 1'b0;
		case (ctl.kind)
			cmsc_pkg::KIND_OPEN: begin
				if (target && ctl.hb_ok) begin
					dir_next     = open_hit ? cmsc_pkg::DIR_STOP : cmsc_pkg::DIR_OPEN;
					elapsed_next = '0;
					state_next   = open_hit ? cmsc_pkg::ST_OPEN : cmsc_pkg::ST_OPENING;
				end
			end
			cmsc_pkg::KIND_CLOSE: begin
				if (target && ctl.hb_ok) begin
					dir_next     = close_hit ? cmsc_pkg::DIR_STOP : cmsc_pkg::DIR_CLOSE;
					elapsed_next = '0;
					state_next   = close_hit ? cmsc_pkg::ST_CLOSED : cmsc_pkg::ST_CLOSING;
				end
			end
			cmsc_pkg::KIND_STOP: begin
				if (target) begin
					dir_next     = cmsc_pkg::DIR_STOP;
					elapsed_next = '0;
					state_next   = cmsc_pkg::ST_STOPPED;
				end
			end
			cmsc_pkg::KIND_STOP_ALL: begin
				if (enable) begin
					dir_next     = cmsc_pkg::DIR_STOP;
					elapsed_next = '0;
					if (state_q == cmsc_pkg::ST_OPENING || state_q == cmsc_pkg::ST_CLOSING)
						state_next = cmsc_pkg::ST_STOPPED;
				end
			end
			cmsc_pkg::KIND_TICK: begin
				if (moving_q)
					elapsed_next = elapsed_inc;
				if (ctl.failsafe_stop && enable) begin
					dir_next     = cmsc_pkg::DIR_STOP;
					elapsed_next = '0;
					if (state_q == cmsc_pkg::ST_OPENING || state_q == cmsc_pkg::ST_CLOSING)
						state_next = cmsc_pkg::ST_STOPPED;
				end else if (ctl.poll_check && enable && moving_q) begin
					if (dir_q == cmsc_pkg::DIR_OPEN && open_hit) begin
						dir_next      = cmsc_pkg::DIR_STOP;
						elapsed_next  = '0;
						state_next    = cmsc_pkg::ST_OPEN;
						endstop_event = 1'b1;
					end else if (dir_q == cmsc_pkg::DIR_CLOSE && close_hit) begin
						dir_next      = cmsc_pkg::DIR_STOP;
						elapsed_next  = '0;
						state_next    = cmsc_pkg::ST_CLOSED;
						endstop_event = 1'b1;
					end else if (max_move != '0 &&
						cmsc_pkg::CFG_DATA_BITS'(elapsed_inc) >= max_move) begin
						dir_next      = cmsc_pkg::DIR_STOP;
						elapsed_next  = '0;
						state_next    = cmsc_pkg::ST_STOPPED;
						timeout_event = 1'b1;
					end
				end
			end
			cmsc_pkg::KIND_INIT: begin
				dir_next     = cmsc_pkg::DIR_STOP;
				elapsed_next = '0;
				if (!enable)
					state_next = cmsc_pkg::ST_UNKNOWN;
				else if (open_hit && close_hit)
					state_next = cmsc_pkg::ST_ERROR;
				else if (open_hit)
					state_next = cmsc_pkg::ST_OPEN;
				else if (close_hit)
					state_next = cmsc_pkg::ST_CLOSED;
				else
					state_next = cmsc_pkg::ST_UNKNOWN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= cmsc_pkg::DIR_STOP;
			state_q   <= cmsc_pkg::ST_UNKNOWN;
			elapsed_q <= '0;
		end else if (ctl.fire) begin
			dir_q     <= dir_next;
			state_q   <= state_next;
			elapsed_q <= elapsed_next;
		end
	end

	// a moving cover always shows the matching in-motion state
	a_open_state: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == cmsc_pkg::DIR_OPEN |-> state_q == cmsc_pkg::ST_OPENING)
		else $error("opening direction without opening state");

	a_close_state: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == cmsc_pkg::DIR_CLOSE |-> state_q == cmsc_pkg::ST_CLOSING)
		else $error("closing direction without closing state");

	// move time only runs while the motor runs
	a_idle_time: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == cmsc_pkg::DIR_STOP |-> elapsed_q == '0)
		else $error("move time nonzero on a stopped cover");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		!(endstop_event && timeout_event))
		else $error("end-stop and timeout on the same cover");

endmodule

// ===== rtl/cmsc_supervisor.sv =====
module cmsc_supervisor #(
	parameter int ACTIVE     = cmsc_pkg::NUM_COVERS_DEF,
	parameter int TIMER_BITS = cmsc_pkg::TIMER_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   fire,
	input  logic [cmsc_pkg::KIND_BITS-1:0]         kind,
	input  logic [cmsc_pkg::REQ_BITS-1:0]          req,
	input  logic [cmsc_pkg::SLOTS-1:0]             open_levels,
	input  logic [cmsc_pkg::SLOTS-1:0]             close_levels,
	input  logic [cmsc_pkg::SLOTS-1:0]             cover_enable,
	input  logic [cmsc_pkg::SLOTS-1:0]             active_low,
	input  logic [cmsc_pkg::CFG_DATA_BITS-1:0]     hb_timeout,
	input  logic [cmsc_pkg::CFG_DATA_BITS-1:0]     poll_interval,
	input  logic                                   any_moving_now,
	output cmsc_pkg::cmsc_ctl_t                    ctl,
	output logic [cmsc_pkg::STATUS_BITS-1:0]       status,
	output logic                                   trip
);

	logic [TIMER_BITS-1:0]          hb_age_q;
	logic [TIMER_BITS-1:0]          poll_age_q;
	logic                           latched_q;
	logic [TIMER_BITS-1:0]          hb_inc;
	logic [TIMER_BITS-1:0]          poll_inc;
	logic                           hb_ok_now;
	logic                           hb_ok_tick;
	logic                           is_tick;
	logic                           req_ok;
	logic                           at_stop;
	logic [cmsc_pkg::SLOT_BITS-1:0] slot;

	assign hb_inc   = &hb_age_q ? hb_age_q : hb_age_q + 1'b1;
	assign poll_inc = &poll_age_q ? poll_age_q : poll_age_q + 1'b1;

	assign hb_ok_now  = hb_timeout == '0 ||
		cmsc_pkg::CFG_DATA_BITS'(hb_age_q) <= hb_timeout;
	assign hb_ok_tick = hb_timeout == '0 ||
		cmsc_pkg::CFG_DATA_BITS'(hb_inc) <= hb_timeout;
	assign is_tick = kind == cmsc_pkg::KIND_TICK;

	assign ctl.fire          = fire;
	assign ctl.kind          = kind;
	assign ctl.req           = req;
	assign ctl.hb_ok         = hb_ok_now;
	assign ctl.failsafe_stop = is_tick && !hb_ok_tick && any_moving_now;
	assign ctl.poll_check    = is_tick && hb_ok_tick &&
		cmsc_pkg::CFG_DATA_BITS'(poll_inc) >= poll_interval;

	assign trip = ctl.failsafe_stop && !latched_q;

	// addressed cover, only meaningful below the cover count
	assign slot    = req[cmsc_pkg::SLOT_BITS-1:0];
	assign req_ok  = req < cmsc_pkg::REQ_BITS'(ACTIVE) && cover_enable[slot];
	assign at_stop = kind == cmsc_pkg::KIND_OPEN ? open_levels[slot] ^ active_low[slot]
		: close_levels[slot] ^ active_low[slot];

	always_comb begin
		status = cmsc_pkg::STATUS_OK;
		case (kind) inside
			cmsc_pkg::KIND_OPEN, cmsc_pkg::KIND_CLOSE: begin
				if (!req_ok)
					status = cmsc_pkg::STATUS_INVALID;
				else if (!hb_ok_now)
					status = cmsc_pkg::STATUS_HB_BAD;
				else if (at_stop)
					status = cmsc_pkg::STATUS_AT_STOP;
			end
			cmsc_pkg::KIND_STOP: begin
				if (!req_ok)
					status = cmsc_pkg::STATUS_INVALID;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_age_q   <= '0;
			poll_age_q <= '0;
			latched_q  <= 1'b0;
		end else if (fire) begin
			case (kind)
				cmsc_pkg::KIND_HEARTBEAT: begin
					hb_age_q  <= '0;
					latched_q <= 1'b0;
				end
				cmsc_pkg::KIND_TICK: begin
					hb_age_q   <= hb_inc;
					poll_age_q <= ctl.poll_check ? '0 : poll_inc;
					if (!hb_ok_tick)
						latched_q <= 1'b1;
				end
				cmsc_pkg::KIND_INIT: begin
					hb_age_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/cover_motor_safety_controller.sv =====
// channel  | dir | handshake    | carries
// cmd      | in  | valid/ready  | kind, cover_req, open_stop_levels, close_stop_levels
// res      | out | valid/ready  | drives, status, cover_states, events, trip, all_stopped
// cfg      | in  | valid/ready  | register index, write data (always ready)
//
// one request per cycle sustained unless the result stalls: a request waits in the
// input register, then the cover slices and supervisor update state and load the
// result register at the same edge, which presents the result on res.
// reset clears flags, state and config, not request or result data; no clearing pass.
// a stalled result holds and the input register still takes one more request.
module cover_motor_safety_controller #(
	parameter int NUM_COVERS = cmsc_pkg::NUM_COVERS_DEF,
	parameter int TIMER_BITS = cmsc_pkg::TIMER_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cmsc_cmd_if.sink cmd,
	cmsc_res_if.source res,
	cmsc_cfg_if.sink cfg
);

	localparam int ACTIVE = NUM_COVERS < cmsc_pkg::SLOTS ? NUM_COVERS : cmsc_pkg::SLOTS;
	localparam int SL     = cmsc_pkg::SLOTS;
	localparam int SB     = cmsc_pkg::STATE_BITS;

	// configuration
	logic [SL-1:0]                        cover_enable_q;
	logic [SL-1:0]                        active_low_q;
	logic [cmsc_pkg::CFG_DATA_BITS-1:0]   hb_timeout_q;
	logic [cmsc_pkg::CFG_DATA_BITS-1:0]   poll_interval_q;
	logic [cmsc_pkg::CFG_DATA_BITS-1:0]   max_move_q [SL];

	// input register
	logic                                 valid_s1;
	logic [cmsc_pkg::KIND_BITS-1:0]       kind_s1;
	logic [cmsc_pkg::REQ_BITS-1:0]        req_s1;
	logic [SL-1:0]                        olv_s1;
	logic [SL-1:0]                        clv_s1;

	// result register
	logic                                 res_valid_q;
	logic [SL-1:0]                        drive_open_q;
	logic [SL-1:0]                        drive_close_q;
	logic [cmsc_pkg::STATUS_BITS-1:0]     status_q;
	logic [SL*SB-1:0]                     cover_states_q;
	logic [SL-1:0]                        endstop_q;
	logic [SL-1:0]                        timeout_q;
	logic                                 trip_q;
	logic                                 all_stopped_q;

	logic                                 res_free;
	logic                                 fire;
	cmsc_pkg::cmsc_ctl_t                  ctl;
	logic [cmsc_pkg::STATUS_BITS-1:0]     status_w;
	logic                                 trip_w;
	logic [cmsc_pkg::DIR_BITS-1:0]        dir_w [SL];
	logic [SB-1:0]                        state_w [SL];
	logic [SL-1:0]                        endstop_w;
	logic [SL-1:0]                        timeout_w;
	logic [SL-1:0]                        moving_w;
	logic [SL-1:0]                        open_w;
	logic [SL-1:0]                        close_w;
	logic [SL*SB-1:0]                     states_w;

	assign res_free  = !res_valid_q || res.ready;
	assign fire      = valid_s1 && res_free;
	assign cmd.ready = !valid_s1 || res_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_enable_q  <= '0;
			active_low_q    <= '0;
			hb_timeout_q    <= '0;
			poll_interval_q <= '0;
			for (int i = 0; i < SL; i++)
				max_move_q[i] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cmsc_pkg::REG_COVER_ENABLE:  cover_enable_q  <= cfg.data[SL-1:0];
				cmsc_pkg::REG_ACTIVE_LOW:    active_low_q    <= cfg.data[SL-1:0];
				cmsc_pkg::REG_HB_TIMEOUT:    hb_timeout_q    <= cfg.data;
				cmsc_pkg::REG_POLL_INTERVAL: poll_interval_q <= cfg.data;
				cmsc_pkg::REG_MAX_MOVE0:     max_move_q[0]   <= cfg.data;
				cmsc_pkg::REG_MAX_MOVE1:     max_move_q[1]   <= cfg.data;
				cmsc_pkg::REG_MAX_MOVE2:     max_move_q[2]   <= cfg.data;
				cmsc_pkg::REG_MAX_MOVE3:     max_move_q[3]   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.valid && cmd.ready)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1 <= cmd.kind;
			req_s1  <= cmd.cover_req;
			olv_s1  <= cmd.open_stop_levels;
			clv_s1  <= cmd.close_stop_levels;
		end
	end

	cmsc_supervisor #(
		.ACTIVE     (ACTIVE),
		.TIMER_BITS (TIMER_BITS)
	) u_sup (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.kind           (kind_s1),
		.req            (req_s1),
		.open_levels    (olv_s1),
		.close_levels   (clv_s1),
		.cover_enable   (cover_enable_q),
		.active_low     (active_low_q),
		.hb_timeout     (hb_timeout_q),
		.poll_interval  (poll_interval_q),
		.any_moving_now (|moving_w),
		.ctl            (ctl),
		.status         (status_w),
		.trip           (trip_w)
	);

	for (genvar i = 0; i < SL; i++) begin : g_cover
		if (i < ACTIVE) begin : g_on
			logic moving_now;
			cmsc_cover #(
				.IDX        (i),
				.TIMER_BITS (TIMER_BITS)
			) u_cover (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl),
				.enable        (cover_enable_q[i]),
				.active_low    (active_low_q[i]),
				.max_move      (max_move_q[i]),
				.open_level    (olv_s1[i]),
				.close_level   (clv_s1[i]),
				.dir_next      (dir_w[i]),
				.state_next    (state_w[i]),
				.endstop_event (endstop_w[i]),
				.timeout_event (timeout_w[i]),
				.moving_now    (moving_now)
			);
			assign moving_w[i] = moving_now;
		end else begin : g_off
			// slots past the cover count never move
			assign dir_w[i]     = cmsc_pkg::DIR_STOP;
			assign state_w[i]   = cmsc_pkg::ST_UNKNOWN;
			assign endstop_w[i] = 1'b0;
			assign timeout_w[i] = 1'b0;
			assign moving_w[i]  = 1'b0;
		end
		assign open_w[i]             = dir_w[i] == cmsc_pkg::DIR_OPEN;
		assign close_w[i]            = dir_w[i] == cmsc_pkg::DIR_CLOSE;
		assign states_w[i*SB +: SB]  = state_w[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			drive_open_q   <= open_w;
			drive_close_q  <= close_w;
			status_q       <= status_w;
			cover_states_q <= states_w;
			endstop_q      <= endstop_w;
			timeout_q      <= timeout_w;
			trip_q         <= trip_w;
			all_stopped_q  <= !(|(cover_enable_q & (open_w | close_w)));
		end
	end

	assign res.valid          = res_valid_q;
	assign res.drive_open     = drive_open_q;
	assign res.drive_close    = drive_close_q;
	assign res.status         = status_q;
	assign res.cover_states   = cover_states_q;
	assign res.endstop_events = endstop_q;
	assign res.timeout_events = timeout_q;
	assign res.failsafe_trip  = trip_q;
	assign res.all_stopped    = all_stopped_q;

endmodule
